FILE: hw/rtl/cftc_pkg.sv
package cftc_pkg;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int POS_W = 5;
    localparam logic [POS_W-1:0] DATE_LEN   = 5'd19;
    localparam logic [POS_W-1:0] POS_DASH_A = 5'd4;
    localparam logic [POS_W-1:0] POS_DASH_B = 5'd7;
    localparam logic [POS_W-1:0] POS_SEP    = 5'd10;
    localparam logic [POS_W-1:0] POS_COLON_A = 5'd13;
    localparam logic [POS_W-1:0] POS_COLON_B = 5'd16;

    localparam logic [1:0] FT_INTEGER  = 2'd0;
    localparam logic [1:0] FT_DECIMAL  = 2'd1;
    localparam logic [1:0] FT_DATETIME = 2'd2;
    localparam logic [1:0] FT_TEXT     = 2'd3;

    typedef struct packed {
        logic has_char;
        logic field_end;
        logic is_digit;
        logic is_sign;
        logic is_point;
        logic is_ws;
        logic is_space;
        logic is_dash;
        logic is_colon;
    } t_beat;

endpackage

FILE: hw/rtl/csv_field_type_classifier.sv
// A last beat is written into the queue; its type code is then registered by the back end.
// Throughput: one beat per cycle unless the input stalls; the queue absorbs QUEUE_DEPTH
// beats while the output stalls. The rate is set by the field state update in the back end.
// Reset is synchronous and active low; it empties the queue, clears the output
// valid and returns the field state to the start of a new field.
module csv_field_type_classifier #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_char_code,
    input  logic       i_has_char,
    input  logic       i_field_end,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_field_type
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cftc_pkg::t_beat w_front_beat;
    cftc_pkg::t_beat w_queue_beat;
    logic            w_push, w_pop, w_full, w_empty;
    logic [CW-1:0]   w_count;

    cftc_front u_front (
        .i_valid     (i_in_valid),
        .i_char_code (i_char_code),
        .i_has_char  (i_has_char),
        .i_field_end (i_field_end),
        .i_full      (w_full),
        .o_stall     (o_in_stall),
        .o_push      (w_push),
        .o_beat      (w_front_beat)
    );

    cftc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_beat  (w_front_beat),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_count (w_count),
        .o_beat  (w_queue_beat)
    );

    cftc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (w_empty),
        .i_beat       (w_queue_beat),
        .i_out_stall  (i_out_stall),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .o_field_type (o_field_type)
    );

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CW'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    a_stall_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall == (w_count == CW'(QUEUE_DEPTH)))
        else $error("input stall does not match queue fill");

    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_count != '0)
        else $error("pop from empty queue");

    a_out_drop_only_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_out_valid) |-> $past(!i_out_stall))
        else $error("result beat dropped while stalled");
`endif

endmodule

FILE: hw/rtl/cftc_front.sv
module cftc_front (
    input  logic             i_valid,
    input  logic [7:0]       i_char_code,
    input  logic             i_has_char,
    input  logic             i_field_end,
    input  logic             i_full,
    output logic             o_stall,
    output logic             o_push,
    output cftc_pkg::t_beat  o_beat
);

    always_comb begin
        o_beat.has_char  = i_has_char;
        o_beat.field_end = i_field_end;
        o_beat.is_digit  = i_char_code inside {[cftc_pkg::CH_ZERO:cftc_pkg::CH_NINE]};
        o_beat.is_sign   = i_char_code inside {cftc_pkg::CH_PLUS, cftc_pkg::CH_MINUS};
        o_beat.is_point  = (i_char_code == cftc_pkg::CH_POINT);
        o_beat.is_ws     = i_char_code inside {[cftc_pkg::CH_TAB:cftc_pkg::CH_CR],
                                               cftc_pkg::CH_SPACE};
        o_beat.is_space  = (i_char_code == cftc_pkg::CH_SPACE);
        o_beat.is_dash   = (i_char_code == cftc_pkg::CH_MINUS);
        o_beat.is_colon  = (i_char_code == cftc_pkg::CH_COLON);
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

endmodule

FILE: hw/rtl/cftc_queue.sv
module cftc_queue #(
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  cftc_pkg::t_beat            i_beat,
    input  logic                       i_pop,
    output logic                       o_full,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count,
    output cftc_pkg::t_beat            o_beat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cftc_pkg::t_beat r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          w_wr, w_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_beat  = r_mem[r_rd_ptr];

    assign w_wr = i_push && !o_full;
    assign w_rd = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_count = r_count + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_beat;
        end
    end

endmodule

FILE: hw/rtl/cftc_back.sv
module cftc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  cftc_pkg::t_beat  i_beat,
    input  logic             i_out_stall,
    output logic             o_pop,
    output logic             o_out_valid,
    output logic [1:0]       o_field_type
);

    logic                       r_at_start, n_at_start;
    logic                       r_int_ok, n_int_ok;
    logic                       r_float_ok, n_float_ok;
    logic                       r_point_seen, n_point_seen;
    logic                       r_date_ok, n_date_ok;
    logic [cftc_pkg::POS_W-1:0] r_date_pos, n_date_pos;
    logic                       r_lead_ws, n_lead_ws;
    logic                       r_out_valid, n_out_valid;
    logic [1:0]                 r_out_type, n_out_type;
    logic                       w_pattern_ok;
    logic                       w_result;

    assign o_pop        = !i_empty && (!i_beat.field_end || !r_out_valid || !i_out_stall);
    assign w_result     = o_pop && i_beat.field_end;
    assign o_out_valid  = r_out_valid;
    assign o_field_type = r_out_type;

    always_comb begin
        case (r_date_pos)
            cftc_pkg::POS_DASH_A, cftc_pkg::POS_DASH_B:   w_pattern_ok = i_beat.is_dash;
            cftc_pkg::POS_COLON_A, cftc_pkg::POS_COLON_B: w_pattern_ok = i_beat.is_colon;
            cftc_pkg::POS_SEP:                            w_pattern_ok = i_beat.is_space;
            default:                                      w_pattern_ok = i_beat.is_digit;
        endcase
    end

    always_comb begin
        n_at_start   = r_at_start;
        n_int_ok     = r_int_ok;
        n_float_ok   = r_float_ok;
        n_point_seen = r_point_seen;
        n_date_ok    = r_date_ok;
        n_date_pos   = r_date_pos;
        n_lead_ws    = r_lead_ws;
        n_out_type   = r_out_type;
        n_out_valid  = r_out_valid && i_out_stall;

        if (i_beat.has_char) begin
            n_at_start = 1'b0;
            if ((r_at_start && i_beat.is_sign) || i_beat.is_digit) begin
                n_int_ok = r_int_ok;
            end else if (i_beat.is_point) begin
                n_int_ok     = 1'b0;
                n_float_ok   = r_float_ok && !r_point_seen;
                n_point_seen = 1'b1;
            end else begin
                n_int_ok   = 1'b0;
                n_float_ok = 1'b0;
            end

            if (!(r_lead_ws && i_beat.is_ws)) begin
                n_lead_ws = 1'b0;
                if (r_date_pos < cftc_pkg::DATE_LEN) begin
                    n_date_ok  = r_date_ok && w_pattern_ok;
                    n_date_pos = r_date_pos + 1'b1;
                end else if (!i_beat.is_ws) begin
                    n_date_ok = 1'b0;
                end
            end
        end

        if (i_beat.field_end) begin
            if (!n_at_start && n_int_ok) begin
                n_out_type = cftc_pkg::FT_INTEGER;
            end else if (!n_at_start && n_float_ok && n_point_seen) begin
                n_out_type = cftc_pkg::FT_DECIMAL;
            end else if (!n_at_start && n_date_ok && n_date_pos == cftc_pkg::DATE_LEN) begin
                n_out_type = cftc_pkg::FT_DATETIME;
            end else begin
                n_out_type = cftc_pkg::FT_TEXT;
            end
            n_at_start   = 1'b1;
            n_int_ok     = 1'b1;
            n_float_ok   = 1'b1;
            n_point_seen = 1'b0;
            n_date_ok    = 1'b1;
            n_date_pos   = '0;
            n_lead_ws    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_start   <= 1'b1;
            r_int_ok     <= 1'b1;
            r_float_ok   <= 1'b1;
            r_point_seen <= 1'b0;
            r_date_ok    <= 1'b1;
            r_date_pos   <= '0;
            r_lead_ws    <= 1'b1;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_pop) begin
                r_at_start   <= n_at_start;
                r_int_ok     <= n_int_ok;
                r_float_ok   <= n_float_ok;
                r_point_seen <= n_point_seen;
                r_date_ok    <= n_date_ok;
                r_date_pos   <= n_date_pos;
                r_lead_ws    <= n_lead_ws;
            end
            r_out_valid <= w_result || n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_result) begin
            r_out_type <= n_out_type;
        end
    end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import cftc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef enum int {GEN_INT, GEN_FLOAT, GEN_DATE, GEN_NOISE} t_field_kind;

    class t_type_checker;
        logic [1:0] pending_types[$];
        int errors;
        bit fresh;
        bit can_int;
        bit can_float;
        bit saw_point;
        bit can_date;
        bit lead_ws;
        logic [POS_W-1:0] date_idx;

        function new();
            errors = 0;
            clear_field();
        endfunction

        function void clear_field();
            fresh = 1'b1;
            can_int = 1'b1;
            can_float = 1'b1;
            saw_point = 1'b0;
            can_date = 1'b1;
            date_idx = '0;
            lead_ws = 1'b1;
        endfunction

        function bit is_digit_ch(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function bit is_space_ch(logic [7:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        function void note_beat(logic [7:0] c, logic has, logic last);
            bit first;
            bit ok;
            logic [1:0] want;
            if (has) begin
                first = fresh;
                fresh = 1'b0;
                if (c == CH_POINT) begin
                    can_int = 1'b0;
                    if (saw_point) begin
                        can_float = 1'b0;
                    end
                    saw_point = 1'b1;
                end else if (!is_digit_ch(c) && !(first && (c == CH_PLUS || c == CH_MINUS))) begin
                    can_int = 1'b0;
                    can_float = 1'b0;
                end
                if (!(lead_ws && is_space_ch(c))) begin
                    lead_ws = 1'b0;
                    if (date_idx < DATE_LEN) begin
                        case (date_idx)
                            POS_DASH_A, POS_DASH_B: ok = (c == CH_MINUS);
                            POS_COLON_A, POS_COLON_B: ok = (c == CH_COLON);
                            POS_SEP: ok = (c == CH_SPACE);
                            default: ok = is_digit_ch(c);
                        endcase
                        if (!ok) begin
                            can_date = 1'b0;
                        end
                        date_idx = date_idx + 1'b1;
                    end else if (!is_space_ch(c)) begin
                        can_date = 1'b0;
                    end
                end
            end
            if (last) begin
                if (!fresh && can_int) begin
                    want = FT_INTEGER;
                end else if (!fresh && can_float && saw_point) begin
                    want = FT_DECIMAL;
                end else if (!fresh && can_date && date_idx == DATE_LEN) begin
                    want = FT_DATETIME;
                end else begin
                    want = FT_TEXT;
                end
                pending_types.push_back(want);
                clear_field();
            end
        endfunction

        function void check_type(logic [1:0] got);
            logic [1:0] want;
            if (pending_types.size() == 0) begin
                $display("%0t: unexpected field type, expected none, got %0d", $time, got);
                errors++;
            end else begin
                want = pending_types.pop_front();
                if (got !== want) begin
                    $display("%0t: field type mismatch, expected %0d, got %0d",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_char_code;
    logic       i_has_char;
    logic       i_field_end;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [1:0] o_field_type;

    t_type_checker board = new();
    logic [7:0] field_chars[$];
    bit calm;
    int beat_count;
    int field_count;
    int cycles = 0;

    csv_field_type_classifier i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_char_code  (i_char_code),
        .i_has_char   (i_has_char),
        .i_field_end  (i_field_end),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_field_type (o_field_type)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= i_rst_n && !calm && ($urandom_range(99) < 30);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                board.note_beat(i_char_code, i_has_char, i_field_end);
            end
            if (o_out_valid && !i_out_stall) begin
                board.check_type(o_field_type);
            end
        end
    end

    function automatic logic [7:0] rand_digit();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_ws();
        int pick;
        pick = $urandom_range(5);
        return (pick == 5) ? CH_SPACE : CH_TAB + 8'(pick);
    endfunction

    function automatic void build_field();
        t_field_kind kind;
        int roll;
        int n;
        field_chars.delete();
        roll = $urandom_range(99);
        if (roll < 25) begin
            kind = GEN_INT;
        end else if (roll < 50) begin
            kind = GEN_FLOAT;
        end else if (roll < 80) begin
            kind = GEN_DATE;
        end else begin
            kind = GEN_NOISE;
        end
        case (kind)
            GEN_INT, GEN_FLOAT: begin
                if ($urandom_range(9) < 3) begin
                    field_chars.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
                end
                n = (kind == GEN_INT && field_chars.size() == 0) ? $urandom_range(1, 6)
                                                                  : $urandom_range(0, 5);
                repeat (n) field_chars.push_back(rand_digit());
                if (kind == GEN_FLOAT) begin
                    field_chars.push_back(CH_POINT);
                    repeat ($urandom_range(0, 4)) field_chars.push_back(rand_digit());
                end
            end
            GEN_DATE: begin
                repeat ($urandom_range(0, 2)) field_chars.push_back(rand_ws());
                for (int p = 0; p < 19; p++) begin
                    if (p == POS_DASH_A || p == POS_DASH_B) begin
                        field_chars.push_back(CH_MINUS);
                    end else if (p == POS_COLON_A || p == POS_COLON_B) begin
                        field_chars.push_back(CH_COLON);
                    end else if (p == POS_SEP) begin
                        field_chars.push_back(CH_SPACE);
                    end else begin
                        field_chars.push_back(rand_digit());
                    end
                end
                repeat ($urandom_range(0, 2)) field_chars.push_back(rand_ws());
                if ($urandom_range(9) == 0) begin
                    void'(field_chars.pop_back());
                end
            end
            default: begin
                repeat ($urandom_range(0, 6)) field_chars.push_back(8'($urandom_range(255)));
            end
        endcase
        if (kind != GEN_NOISE && field_chars.size() > 0 && $urandom_range(9) < 2) begin
            field_chars[$urandom_range(field_chars.size() - 1)] = 8'($urandom_range(255));
        end
    endfunction

    task automatic send_beat(logic [7:0] c, logic has, logic last);
        if (!calm && $urandom_range(99) < 30) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_char_code <= c;
        i_has_char  <= has;
        i_field_end <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        beat_count++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) begin
            send_beat(s[i], 1'b1, i == s.len() - 1);
        end
    endtask

    task automatic send_field();
        int n;
        bit empty_end;
        n = field_chars.size();
        empty_end = (n == 0) || ($urandom_range(9) == 0);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0) begin
                send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
            end
            send_beat(field_chars[i], 1'b1, !empty_end && i == n - 1);
        end
        if (empty_end) begin
            send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
        end
    endtask

    initial begin
        calm        = 1'b0;
        beat_count  = 0;
        field_count = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_char_code <= 8'h00;
        i_has_char  <= 1'b0;
        i_field_end <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_beat(8'hA5, 1'b0, 1'b1);
        send_text("-");
        send_text("+7");
        send_text("-.5");
        send_text("1.2.");
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'h5A, 1'b0, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b1);
        send_beat(8'h34, 1'b1, 1'b0);
        send_beat(8'hC3, 1'b0, 1'b1);
        send_text("9+");

        while (beat_count < 420 || field_count < 50) begin
            calm = (field_count >= 20 && field_count < 30);
            if (field_count == 35) begin
                // Hold the input off until every pending type code has drained.
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (board.pending_types.size() != 0);
            end
            build_field();
            send_field();
            field_count++;
        end

        i_in_valid <= 1'b0;
        while (board.pending_types.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (board.errors == 0 && board.pending_types.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
